// ===== hdl/lpft_pkg.sv =====
package lpft_pkg;

  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd3;
  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic hit_seen;
    logic free_seen;
  } chain_t;

  typedef struct packed {
    logic apply;
    logic hit;
    logic fill;
    logic evict;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } st_t;

endpackage

// ===== hdl/lpft_ifs.sv =====
interface lpft_in_if #(
  parameter int PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface lpft_out_if #(
  parameter int PAGE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          evicted_valid;
  logic [PAGE_BITS-1:0]          evicted_page;
  logic [lpft_pkg::CNT_W-1:0]    fault_total;
  logic [lpft_pkg::CNT_W-1:0]    hit_total;

  modport source (output valid, output hit, output evicted_valid, output evicted_page,
                  output fault_total, output hit_total, input ready);
  modport sink (input valid, input hit, input evicted_valid, input evicted_page,
                input fault_total, input hit_total, output ready);
endinterface

interface lpft_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lpft_pkg::CFG_W-1:0] frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink (input valid, input frames_in_use, output ready);
endinterface

// ===== hdl/lpft_cell.sv =====
module lpft_cell #(
  parameter int PAGE_BITS = 16,
  parameter int RANK_W    = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [PAGE_BITS-1:0] ref_page,
  input  lpft_pkg::cmd_t       cmd,
  input  logic [RANK_W-1:0]    pivot_rank,
  input  logic [RANK_W-1:0]    lru_rank,
  input  lpft_pkg::chain_t     chain_in,
  output lpft_pkg::chain_t     chain_out,
  input  logic [PAGE_BITS-1:0] ev_page_in,
  output logic [PAGE_BITS-1:0] ev_page_out,
  input  logic [RANK_W-1:0]    hit_rank_in,
  output logic [RANK_W-1:0]    hit_rank_out
);

  logic                 valid_r, valid_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic                 match, hit_sel, free_sel, lru_sel, target;

  always_comb begin
    match    = valid_r && (page_r == ref_page);
    hit_sel  = match && !chain_in.hit_seen;
    free_sel = !valid_r && !chain_in.free_seen;
    lru_sel  = valid_r && (rank_r == lru_rank);

    chain_out.hit_seen  = chain_in.hit_seen | match;
    chain_out.free_seen = chain_in.free_seen | !valid_r;
    ev_page_out  = ev_page_in | (lru_sel ? page_r : '0);
    hit_rank_out = hit_rank_in | (hit_sel ? rank_r : '0);

    target = (cmd.hit && hit_sel) || (cmd.fill && free_sel) || (cmd.evict && lru_sel);
  end

  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    rank_nxt  = rank_r;
    if (cmd.apply) begin
      if (target) begin
        rank_nxt = '0;
        if (cmd.fill || cmd.evict) begin
          page_nxt  = ref_page;
          valid_nxt = 1'b1;
        end
      end else if (valid_r && (cmd.fill || rank_r < pivot_rank)) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      page_r  <= '0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      page_r  <= page_nxt;
      rank_r  <= rank_nxt;
    end
  end

endmodule

// ===== hdl/lru_page_frame_tracker.sv =====
// Fully associative page-frame tracker with least-recently-used replacement, built
// as a row of MAX_FRAMES frame cells. Each cell holds one page, its valid bit and
// its recency rank; match, first-free and first-hit flags ripple from cell to cell.
// A reference is captured in the accept state (ST_IDLE) and applied to all cells and
// the result register in ST_APPLY, so the block takes no new word until the current
// one has been applied; a stalled result holds the apply step.
// frames_in_use is clamped to 1..MAX_FRAMES; fault and hit totals saturate.
module lru_page_frame_tracker #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input logic        clk,
  input logic        rst_n,
  lpft_in_if.sink    in_chan,
  lpft_out_if.source out_chan,
  lpft_cfg_if.sink   cfg_chan
);

  localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int USED_W = $clog2(MAX_FRAMES + 1);
  localparam int LIM_W  = (USED_W > lpft_pkg::CFG_W) ? USED_W : lpft_pkg::CFG_W;
  localparam int CW     = lpft_pkg::CNT_W;

  lpft_pkg::st_t                state_r, state_nxt;
  logic [lpft_pkg::CFG_W-1:0]   limit_cfg_r;
  logic [PAGE_BITS-1:0]         page_r;
  logic [USED_W-1:0]            used_r, used_nxt;
  logic [CW-1:0]                fault_cnt_r, fault_cnt_nxt;
  logic [CW-1:0]                hit_cnt_r, hit_cnt_nxt;

  logic                         out_valid_r;
  logic                         out_hit_r;
  logic                         out_ev_valid_r;
  logic [PAGE_BITS-1:0]         out_ev_page_r;
  logic [CW-1:0]                out_fault_r;
  logic [CW-1:0]                out_hit_tot_r;

  logic                         in_ready;
  logic                         slot_free;
  logic                         apply;
  logic [LIM_W-1:0]             limit_ext;
  logic [LIM_W-1:0]             limit;
  logic [LIM_W-1:0]             used_ext;
  logic                         any_hit, any_free;
  logic                         do_fill, do_evict;
  logic [RANK_W-1:0]            lru_rank, pivot_rank;
  lpft_pkg::cmd_t               cmd;

  lpft_pkg::chain_t             chain [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0]         ev_page [MAX_FRAMES+1];
  logic [RANK_W-1:0]            hit_rank [MAX_FRAMES+1];

  assign chain[0]    = '0;
  assign ev_page[0]  = '0;
  assign hit_rank[0] = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lpft_cell #(
      .PAGE_BITS (PAGE_BITS),
      .RANK_W    (RANK_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ref_page     (page_r),
      .cmd          (cmd),
      .pivot_rank   (pivot_rank),
      .lru_rank     (lru_rank),
      .chain_in     (chain[g]),
      .chain_out    (chain[g+1]),
      .ev_page_in   (ev_page[g]),
      .ev_page_out  (ev_page[g+1]),
      .hit_rank_in  (hit_rank[g]),
      .hit_rank_out (hit_rank[g+1])
    );
  end

  assign slot_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpft_pkg::ST_IDLE: begin
        if (in_chan.valid) state_nxt = lpft_pkg::ST_APPLY;
      end
      lpft_pkg::ST_APPLY: begin
        if (slot_free) state_nxt = lpft_pkg::ST_IDLE;
      end
      default: state_nxt = lpft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    apply    = 1'b0;
    case (state_r)
      lpft_pkg::ST_IDLE:  in_ready = 1'b1;
      lpft_pkg::ST_APPLY: apply    = slot_free;
      default: begin
        in_ready = 1'b0;
        apply    = 1'b0;
      end
    endcase
  end

  always_comb begin
    limit_ext = LIM_W'(limit_cfg_r);
    if (limit_ext == '0) begin
      limit = LIM_W'(1);
    end else if (limit_ext > LIM_W'(MAX_FRAMES)) begin
      limit = LIM_W'(MAX_FRAMES);
    end else begin
      limit = limit_ext;
    end
    used_ext = LIM_W'(used_r);

    any_hit  = chain[MAX_FRAMES].hit_seen;
    any_free = chain[MAX_FRAMES].free_seen;
    do_fill  = !any_hit && any_free && (used_ext < limit);
    do_evict = !any_hit && !do_fill && (used_r != '0);
    lru_rank = RANK_W'(used_r - USED_W'(1));
    pivot_rank = any_hit ? hit_rank[MAX_FRAMES] : lru_rank;

    cmd.apply = apply;
    cmd.hit   = any_hit;
    cmd.fill  = do_fill;
    cmd.evict = do_evict;

    used_nxt      = used_r;
    fault_cnt_nxt = fault_cnt_r;
    hit_cnt_nxt   = hit_cnt_r;
    if (apply) begin
      if (do_fill) used_nxt = used_r + USED_W'(1);
      if (any_hit) begin
        if (hit_cnt_r != lpft_pkg::CNT_MAX) hit_cnt_nxt = hit_cnt_r + CW'(1);
      end else begin
        if (fault_cnt_r != lpft_pkg::CNT_MAX) fault_cnt_nxt = fault_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpft_pkg::ST_IDLE;
      limit_cfg_r <= lpft_pkg::FRAMES_RESET;
      used_r      <= '0;
      fault_cnt_r <= '0;
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      if (cfg_chan.valid) limit_cfg_r <= cfg_chan.frames_in_use;
      if (apply) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_ready) page_r <= in_chan.page_number;
    if (apply) begin
      out_hit_r      <= any_hit;
      out_ev_valid_r <= do_evict;
      out_ev_page_r  <= do_evict ? ev_page[MAX_FRAMES] : '0;
      out_fault_r    <= fault_cnt_nxt;
      out_hit_tot_r  <= hit_cnt_nxt;
    end
  end

  assign in_chan.ready          = in_ready;
  assign cfg_chan.ready         = 1'b1;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.hit           = out_hit_r;
  assign out_chan.evicted_valid = out_ev_valid_r;
  assign out_chan.evicted_page  = out_ev_page_r;
  assign out_chan.fault_total   = out_fault_r;
  assign out_chan.hit_total     = out_hit_tot_r;

endmodule
